[design/htd_pkg.sv]
// Shared constants, codes and the node record of the code tree decoder.
`default_nettype none

package htd_pkg;

  // Tree sizing
  localparam int NODE_COUNT    = 512;
  localparam int MAX_CODE_BITS = 30;
  localparam int NODE_W        = $clog2(NODE_COUNT);
  localparam int FREE_W        = $clog2(NODE_COUNT + 1);
  localparam int CNT_W         = $clog2(MAX_CODE_BITS + 1);

  // Field widths
  localparam int OP_W      = 2;
  localparam int CODE_W    = 30;
  localparam int LEN_W     = 5;
  localparam int SYM_W     = 9;
  localparam int BYTE_W    = 8;
  localparam int KIND_W    = 3;
  localparam int DEPTH_W   = 5;
  localparam int BITCNT_W  = $clog2(BYTE_W + 1);
  localparam int STATUS_W  = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DECODE = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_INSERTED  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SYMBOL    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_STR_OK    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_STR_ERROR = 3'd3;
  localparam logic [KIND_W-1:0] KIND_HIT       = 3'd4;
  localparam logic [KIND_W-1:0] KIND_MISS      = 3'd5;
  localparam logic [KIND_W-1:0] KIND_FULL      = 3'd6;

  // String status codes
  localparam logic [STATUS_W-1:0] ST_ACTIVE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EOS    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FAILED = 2'd2;

  localparam logic [SYM_W-1:0]   SYM_EOS   = 9'd256;
  localparam logic [DEPTH_W-1:0] PAD_MAX   = 5'd7;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = 5'd31;

  // One tree node: child links (0 = none), leaf flag and symbol
  typedef struct packed {
    logic [1:0][NODE_W-1:0] kid;
    logic                   leaf;
    logic [SYM_W-1:0]       sym;
  } node_t;

  localparam int NODE_BITS = $bits(node_t);

endpackage

`default_nettype wire

[design/htd_in_if.sv]
// Input channel of the code tree decoder: handshake and request word.
`default_nettype none

interface htd_in_if;
  import htd_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [CODE_W-1:0] code_bits;
  logic [LEN_W-1:0]  code_length;
  logic [SYM_W-1:0]  symbol_in;
  logic [BYTE_W-1:0] data_byte;
  logic              final_byte;

  modport source (
    output valid, op, code_bits, code_length, symbol_in, data_byte, final_byte,
    input  ready
  );

  modport sink (
    input  valid, op, code_bits, code_length, symbol_in, data_byte, final_byte,
    output ready
  );

endinterface

`default_nettype wire

[design/htd_out_if.sv]
// Output channel of the code tree decoder: handshake and result word.
`default_nettype none

interface htd_out_if;
  import htd_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [SYM_W-1:0]  symbol_out;
  logic              run_end;

  modport source (
    output valid, kind, symbol_out, run_end,
    input  ready
  );

  modport sink (
    input  valid, kind, symbol_out, run_end,
    output ready
  );

endinterface

`default_nettype wire

[design/htd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module htd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

[design/huffman_tree_decoder_top.sv]
// Top level of the code tree decoder: tree walker, inserter and string decoder.
// Usage:
//   in_i carries one request word per valid/ready handshake: insert a code with
//   a symbol, look up a code, or decode one string byte (MSB first). out_o gives
//   result words; run_end marks the last word caused by a request. A request
//   with op 3 is dropped and gives no word.
// Steps (through one node RAM with registered read data, one read per cycle):
//   decode: take the byte's bits MSB first, resolving each node reached and
//     then the last one, flush the held symbol, and on a final byte give the
//     string status; the walk stops early once the string has ended or failed.
//   lookup: walk the code's bits from the root, then give the result.
//   insert: walk the existing nodes to the missing child, write one new node
//     per remaining bit plus the leaf, then give the result.
//   in_i.ready is high only in the idle state between requests.
// Reset: the tree is empty (the root is held in flops, other nodes are written
//   when allocated, so no clearing pass is needed) and the string state starts.
// Back-pressure: results go through an output register; while it is full and
//   out_o.ready is low, a word that is ready waits, and the string walk holds
//   its place on a new symbol while one is held; both resume when it drains.
`default_nettype none

module huffman_tree_decoder_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  htd_in_if.sink    in_i,
  htd_out_if.source out_o
);
  import htd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_WALK,
    S_INS_WRITE,
    S_LOOK_WALK,
    S_DEC_WALK,
    S_DEC_END,
    S_EMIT
  } state_e;

  state_e state_q;

  // request registers
  logic [CODE_W-1:0]   code_q;
  logic [SYM_W-1:0]    sym_q;
  logic [BYTE_W-1:0]   byte_q;
  logic [BITCNT_W-1:0] bits_q;
  logic                final_q;
  logic [CNT_W-1:0]    i_q;

  // insert / lookup walk
  logic [NODE_W-1:0]   cur_q;
  node_t               node_q;
  logic [FREE_W-1:0]   next_free_q;
  node_t               root_q;

  // string state
  logic [NODE_W-1:0]   walk_q;
  logic                arrived_q;
  logic                arr_bit_q;
  logic [DEPTH_W-1:0]  depth_q;
  logic                ones_q;
  logic [STATUS_W-1:0] status_q;
  logic                pend_valid_q;
  logic [SYM_W-1:0]    pend_sym_q;

  // single result of insert / lookup
  logic [KIND_W-1:0]   res_kind_q;
  logic [SYM_W-1:0]    res_sym_q;

  // output register
  logic                out_valid_q;
  logic [KIND_W-1:0]   out_kind_q;
  logic [SYM_W-1:0]    out_sym_q;
  logic                out_end_q;

  // RAM side
  logic [NODE_W-1:0]   rd_addr;
  logic [NODE_W-1:0]   rd_addr_q;
  logic [NODE_BITS-1:0] ram_rdata;
  logic                ram_we;
  node_t               wr_node;
  node_t               rd_node;

  // combinational helpers
  logic                in_fire;
  logic                bad_len;
  logic                can_emit;
  logic [CODE_W-1:0]   code_sh;
  logic                cur_bit;
  logic [NODE_W-1:0]   child;
  logic [FREE_W-1:0]   avail;
  logic                need_full;
  logic                walk_adv;
  logic                dec_leaf;
  logic                dec_eos;
  logic                dec_sym;
  logic                dec_stall;
  node_t               dec_base;
  logic                dec_bit;
  logic [NODE_W-1:0]   dec_nx;
  logic                dec_can_take;
  logic                dec_take;
  logic                dec_fail;
  logic                str_ok;
  logic                emit_req;
  logic [KIND_W-1:0]   emit_kind;
  logic [SYM_W-1:0]    emit_sym;
  logic                emit_end;
  logic                emit_fire;

  // handshakes
  assign in_i.ready       = (state_q == S_IDLE);
  assign in_fire          = in_i.valid && in_i.ready;
  assign can_emit         = !out_valid_q || out_o.ready;
  assign out_o.valid      = out_valid_q;
  assign out_o.kind       = out_kind_q;
  assign out_o.symbol_out = out_sym_q;
  assign out_o.run_end    = out_end_q;

  assign bad_len = (in_i.code_length == '0) || (32'(in_i.code_length) > MAX_CODE_BITS);

  // node data; the root lives in flops
  assign rd_node = (rd_addr_q == '0) ? root_q : node_t'(ram_rdata);

  // code walk: current code bit and the child it selects
  assign code_sh   = code_q >> (i_q - 1'b1);
  assign cur_bit   = code_sh[0];
  assign child     = rd_node.kid[cur_bit];
  assign avail     = FREE_W'(NODE_COUNT) - next_free_q;
  assign need_full = 32'(i_q) > 32'(avail);
  assign walk_adv  = (i_q != '0) && (child != '0);

  // string walk: resolve the node reached, then take the next bit
  assign dec_leaf     = arrived_q && rd_node.leaf;
  assign dec_eos      = dec_leaf && (rd_node.sym == SYM_EOS);
  assign dec_sym      = dec_leaf && !dec_eos;
  assign dec_stall    = dec_sym && pend_valid_q && !can_emit;
  assign dec_base     = dec_sym ? root_q : rd_node;
  assign dec_bit      = byte_q[BYTE_W-1];
  assign dec_nx       = dec_base.kid[dec_bit];
  assign dec_can_take = !dec_eos && (status_q == ST_ACTIVE) && (bits_q != '0);
  assign dec_take     = dec_can_take && (dec_nx != '0);
  assign dec_fail     = dec_can_take && (dec_nx == '0);

  assign str_ok = (status_q == ST_EOS) ||
                  ((status_q == ST_ACTIVE) && (depth_q <= PAD_MAX) && ones_q);

  // read address
  always_comb begin
    rd_addr = walk_q;
    unique case (state_q)
      S_IDLE: begin
        rd_addr = (in_i.valid && (in_i.op != OP_DECODE)) ? '0 : walk_q;
      end
      S_INS_WALK, S_LOOK_WALK: begin
        rd_addr = walk_adv ? child : cur_q;
      end
      S_INS_WRITE: begin
        rd_addr = cur_q;
      end
      S_DEC_WALK: begin
        rd_addr = (dec_take && !dec_stall) ? dec_nx : walk_q;
      end
      default: begin
        rd_addr = walk_q;
      end
    endcase
  end

  // node write: link a new child, or mark the leaf
  always_comb begin
    wr_node = node_q;
    if (i_q != '0) begin
      wr_node.kid[cur_bit] = next_free_q[NODE_W-1:0];
    end else begin
      wr_node.leaf = 1'b1;
      wr_node.sym  = sym_q;
    end
  end
  assign ram_we = (state_q == S_INS_WRITE);

  // result word to the output register
  always_comb begin
    emit_req  = 1'b0;
    emit_kind = KIND_SYMBOL;
    emit_sym  = '0;
    emit_end  = 1'b0;
    unique case (state_q)
      S_EMIT: begin
        emit_req  = 1'b1;
        emit_kind = res_kind_q;
        emit_sym  = res_sym_q;
        emit_end  = 1'b1;
      end
      S_DEC_WALK: begin
        emit_req  = dec_sym && pend_valid_q;
        emit_kind = KIND_SYMBOL;
        emit_sym  = pend_sym_q;
      end
      S_DEC_END: begin
        if (pend_valid_q) begin
          emit_req  = 1'b1;
          emit_kind = KIND_SYMBOL;
          emit_sym  = pend_sym_q;
          emit_end  = !final_q;
        end else begin
          emit_req  = final_q;
          emit_kind = str_ok ? KIND_STR_OK : KIND_STR_ERROR;
          emit_end  = 1'b1;
        end
      end
      default: begin
        emit_req = 1'b0;
      end
    endcase
  end
  assign emit_fire = emit_req && can_emit;

  htd_ram #(
    .WIDTH (NODE_BITS),
    .DEPTH (NODE_COUNT)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cur_q),
    .wdata_i (wr_node),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // control, walk state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      code_q       <= '0;
      sym_q        <= '0;
      byte_q       <= '0;
      bits_q       <= '0;
      final_q      <= 1'b0;
      i_q          <= '0;
      cur_q        <= '0;
      node_q       <= '0;
      next_free_q  <= FREE_W'(1);
      root_q       <= '0;
      walk_q       <= '0;
      arrived_q    <= 1'b0;
      arr_bit_q    <= 1'b0;
      depth_q      <= '0;
      ones_q       <= 1'b1;
      status_q     <= ST_ACTIVE;
      pend_valid_q <= 1'b0;
      pend_sym_q   <= '0;
      res_kind_q   <= KIND_INSERTED;
      res_sym_q    <= '0;
      out_valid_q  <= 1'b0;
      out_kind_q   <= KIND_INSERTED;
      out_sym_q    <= '0;
      out_end_q    <= 1'b0;
      rd_addr_q    <= '0;
    end else begin
      rd_addr_q <= rd_addr;

      // output register
      if (emit_fire) begin
        out_valid_q <= 1'b1;
        out_kind_q  <= emit_kind;
        out_sym_q   <= emit_sym;
        out_end_q   <= emit_end;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            code_q  <= in_i.code_bits;
            sym_q   <= in_i.symbol_in;
            byte_q  <= in_i.data_byte;
            final_q <= in_i.final_byte;
            bits_q  <= BITCNT_W'(BYTE_W);
            i_q     <= CNT_W'(in_i.code_length);
            cur_q   <= '0;
            res_sym_q <= '0;
            case (in_i.op)
              OP_INSERT: begin
                if (bad_len) begin
                  res_kind_q <= KIND_FULL;
                  state_q    <= S_EMIT;
                end else begin
                  state_q <= S_INS_WALK;
                end
              end
              OP_LOOKUP: begin
                if (bad_len) begin
                  res_kind_q <= KIND_MISS;
                  state_q    <= S_EMIT;
                end else begin
                  state_q <= S_LOOK_WALK;
                end
              end
              OP_DECODE: begin
                state_q <= S_DEC_WALK;
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end

        // follow existing nodes, then check room for the rest
        S_INS_WALK: begin
          if (walk_adv) begin
            cur_q <= child;
            i_q   <= i_q - 1'b1;
          end else begin
            node_q <= rd_node;
            if (need_full) begin
              res_kind_q <= KIND_FULL;
              state_q    <= S_EMIT;
            end else begin
              state_q <= S_INS_WRITE;
            end
          end
        end

        // one node write per cycle: new links, then the leaf
        S_INS_WRITE: begin
          if (cur_q == '0) begin
            root_q <= wr_node;
          end
          if (i_q != '0) begin
            cur_q       <= next_free_q[NODE_W-1:0];
            node_q      <= '0;
            next_free_q <= next_free_q + 1'b1;
            i_q         <= i_q - 1'b1;
          end else begin
            res_kind_q <= KIND_INSERTED;
            state_q    <= S_EMIT;
          end
        end

        S_LOOK_WALK: begin
          if (i_q == '0) begin
            res_kind_q <= rd_node.leaf ? KIND_HIT : KIND_MISS;
            res_sym_q  <= rd_node.leaf ? rd_node.sym : '0;
            state_q    <= S_EMIT;
          end else if (child == '0) begin
            res_kind_q <= KIND_MISS;
            state_q    <= S_EMIT;
          end else begin
            cur_q <= child;
            i_q   <= i_q - 1'b1;
          end
        end

        S_DEC_WALK: begin
          if (!dec_stall) begin
            // resolve the node just reached
            if (dec_sym) begin
              pend_valid_q <= 1'b1;
              pend_sym_q   <= rd_node.sym;
              depth_q      <= '0;
              ones_q       <= 1'b1;
              walk_q       <= '0;
            end else if (dec_eos) begin
              status_q <= ST_EOS;
            end else if (arrived_q) begin
              if (depth_q != DEPTH_MAX) begin
                depth_q <= depth_q + 1'b1;
              end
              ones_q <= ones_q && arr_bit_q;
            end
            arrived_q <= 1'b0;
            // take the next bit
            if (dec_take) begin
              walk_q    <= dec_nx;
              arrived_q <= 1'b1;
              arr_bit_q <= dec_bit;
              bits_q    <= bits_q - 1'b1;
              byte_q    <= {byte_q[BYTE_W-2:0], 1'b0};
            end else begin
              if (dec_fail) begin
                status_q <= ST_FAILED;
              end
              state_q <= S_DEC_END;
            end
          end
        end

        // flush the held symbol, then the string status on the last byte
        S_DEC_END: begin
          if (pend_valid_q) begin
            if (can_emit) begin
              pend_valid_q <= 1'b0;
              if (!final_q) begin
                state_q <= S_IDLE;
              end
            end
          end else if (final_q) begin
            if (can_emit) begin
              walk_q    <= '0;
              arrived_q <= 1'b0;
              depth_q   <= '0;
              ones_q    <= 1'b1;
              status_q  <= ST_ACTIVE;
              state_q   <= S_IDLE;
            end
          end else begin
            state_q <= S_IDLE;
          end
        end

        S_EMIT: begin
          if (can_emit) begin
            state_q <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // allocation pointer stays within the node RAM
  a_free_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (next_free_q != '0) && (32'(next_free_q) <= NODE_COUNT))
    else $error("next free node out of range");

  // the string walk only stands on allocated nodes
  a_walk_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(walk_q) < 32'(next_free_q))
    else $error("string walk on unallocated node");

  // node writes only while inserting, and only to allocated nodes
  a_write_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_INS_WRITE) && (32'(cur_q) < 32'(next_free_q)))
    else $error("node write outside insert");

  // a held symbol never outlives its byte
  a_pend_scope: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> (state_q == S_DEC_WALK) || (state_q == S_DEC_END))
    else $error("held symbol outside decode");

  // between requests the string walk rests on a resolved node
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !arrived_q)
    else $error("unresolved node while idle");

  // an accepted byte starts a full eight-bit walk
  a_dec_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_i.op == OP_DECODE)) |=>
      (state_q == S_DEC_WALK) && (bits_q == BITCNT_W'(BYTE_W)))
    else $error("decode did not start");

endmodule

`default_nettype wire
